// ===== rtl/npq_pkg.sv =====
// Package for the nearest palette color quantizer.
// Holds the palette as per-channel level codes, candidate type and compare helper.
// No dependencies.
package npq_pkg;

  localparam int PalSize   = 16;
  localparam int NumChan   = 3;
  localparam int NumLevels = 4;
  localparam int ChanW     = 8;
  localparam int SqW       = 2 * ChanW;
  localparam int DistW     = SqW + 2;
  localparam int IdxW      = 4;
  localparam int LvlW      = 2;
  localparam int GrpSize   = 4;
  localparam int NumGrp    = PalSize / GrpSize;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [LvlW-1:0]  lvl_t;

  // Distinct channel values used by the palette.
  localparam logic [NumLevels-1:0][ChanW-1:0] LvlVal =
    {8'd255, 8'd192, 8'd128, 8'd0};

  // Level code of each palette entry, entry 15 first.
  localparam logic [PalSize-1:0][LvlW-1:0] PalR = {
    2'd3, 2'd0, 2'd3, 2'd0, 2'd3, 2'd0, 2'd3, 2'd1,
    2'd2, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0};
  localparam logic [PalSize-1:0][LvlW-1:0] PalG = {
    2'd3, 2'd3, 2'd0, 2'd0, 2'd3, 2'd3, 2'd0, 2'd1,
    2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0};
  localparam logic [PalSize-1:0][LvlW-1:0] PalB = {
    2'd3, 2'd3, 2'd3, 2'd3, 2'd0, 2'd0, 2'd0, 2'd1,
    2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0};

  typedef struct packed {
    logic [DistW-1:0] dist_sq;
    logic [IdxW-1:0]  idx;
  } cand_t;

  // Left operand holds the lower indexes; right wins only when strictly nearer.
  function automatic cand_t pick_cand(input cand_t lo, input cand_t hi);
    cand_t res;
    res = (hi.dist_sq < lo.dist_sq) ? hi : lo;
    return res;
  endfunction

endpackage

// ===== rtl/npq_min4.sv =====
// Two-level compare tree: nearest of four candidates, lowest index on ties.
// Depends on npq_pkg.
module npq_min4 (
  input  npq_pkg::cand_t [npq_pkg::GrpSize-1:0] cand_i,
  output npq_pkg::cand_t                        min_o
);

  npq_pkg::cand_t lo_pair;
  npq_pkg::cand_t hi_pair;

  always_comb begin
    lo_pair = npq_pkg::pick_cand(cand_i[0], cand_i[1]);
    hi_pair = npq_pkg::pick_cand(cand_i[2], cand_i[3]);
    min_o   = npq_pkg::pick_cand(lo_pair, hi_pair);
  end

endmodule

// ===== rtl/nearest_palette_color_quantizer.sv =====
// Nearest 16-color palette quantizer, top level.
// Throughput one item per cycle while the output is not stalled.
// Stages: channel squares, per-entry distance sums, 16-to-4 min, 4-to-1 min.
// Each stage holds its item under back-pressure; no item is lost or repeated.
// Reset clears the stage valid bits only; data registers are not reset.
// Depends on npq_pkg and npq_min4.
module nearest_palette_color_quantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // palette_index [3:0], zero [7:4]
);

  localparam int NumStg = 4;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] rdy;

  npq_pkg::chan_t [npq_pkg::NumChan-1:0] chan;
  logic [npq_pkg::NumChan-1:0][npq_pkg::NumLevels-1:0][npq_pkg::SqW-1:0] sq_d, sq_q;
  npq_pkg::cand_t [npq_pkg::PalSize-1:0] dist_d, dist_q;
  npq_pkg::cand_t [npq_pkg::NumGrp-1:0]  grp_d, grp_q;
  npq_pkg::cand_t                        best;
  logic [npq_pkg::IdxW-1:0]              idx_q;

  assign chan[0] = s_axis_tdata[7:0];
  assign chan[1] = s_axis_tdata[15:8];
  assign chan[2] = s_axis_tdata[23:16];

  // Ready chain: a stage takes a new item when empty or when its item moves on.
  assign rdy[3] = !vld_q[3] || m_axis_tready;
  assign rdy[2] = !vld_q[2] || rdy[3];
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[3];
  assign m_axis_tdata  = {4'd0, idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= s_axis_tvalid;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
    end
  end

  // Stage 1: squared difference against each palette level, per channel.
  always_comb begin
    for (int c = 0; c < npq_pkg::NumChan; c++) begin
      for (int l = 0; l < npq_pkg::NumLevels; l++) begin
        logic [npq_pkg::ChanW-1:0] diff;
        diff = (chan[c] >= npq_pkg::LvlVal[l]) ? chan[c] - npq_pkg::LvlVal[l]
                                               : npq_pkg::LvlVal[l] - chan[c];
        sq_d[c][l] = npq_pkg::SqW'(diff) * npq_pkg::SqW'(diff);
      end
    end
  end

  // Stage 2: distance to every palette entry.
  always_comb begin
    for (int k = 0; k < npq_pkg::PalSize; k++) begin
      dist_d[k].dist_sq = npq_pkg::DistW'(sq_q[0][npq_pkg::PalR[k]])
                        + npq_pkg::DistW'(sq_q[1][npq_pkg::PalG[k]])
                        + npq_pkg::DistW'(sq_q[2][npq_pkg::PalB[k]]);
      dist_d[k].idx     = npq_pkg::IdxW'(k);
    end
  end

  // Stage 3: nearest within each group of four.
  for (genvar g = 0; g < npq_pkg::NumGrp; g++) begin : g_grp
    npq_min4 u_grp_min (
      .cand_i (dist_q[g*npq_pkg::GrpSize +: npq_pkg::GrpSize]),
      .min_o  (grp_d[g])
    );
  end

  // Stage 4: nearest over the group winners.
  npq_min4 u_fin_min (
    .cand_i (grp_q),
    .min_o  (best)
  );

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && rdy[0]) sq_q   <= sq_d;
    if (vld_q[0] && rdy[1])      dist_q <= dist_d;
    if (vld_q[1] && rdy[2])      grp_q  <= grp_d;
    if (vld_q[2] && rdy[3])      idx_q  <= best.idx;
  end

  logic in_fire;
  logic out_fire;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  a_ready_follows_sink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_fill_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_fire) |=> $countones(vld_q) == $past($countones(vld_q)) + 1)
    else $error("accepted item not held in pipeline");

  a_fill_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && out_fire) |=> $countones(vld_q) == $past($countones(vld_q)) - 1)
    else $error("delivered item not removed from pipeline");

  a_fill_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire == out_fire) |=> $countones(vld_q) == $past($countones(vld_q)))
    else $error("pipeline occupancy changed without a transfer");

endmodule
